/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl modules
// both forms sample on aclk and are disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every sampled edge
`define FDF_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("fdf assertion failed");
// expression must never be true at a sampled edge
`define FDF_NEVER(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("fdf forbidden condition seen");
`else
`define FDF_ASSERT(label, prop)
`define FDF_NEVER(label, expr)
`endif

`endif

/* rtl/fdf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fdf_pkg;

    // display geometry
    localparam int SCREEN_WIDTH  = 84;
    localparam int SCREEN_HEIGHT = 48;
    localparam int PAGE_ROWS     = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_ROWS;

    // derived widths
    localparam int ADDR_W      = $clog2(STORE_SIZE);
    localparam int COL_W       = $clog2(SCREEN_WIDTH);
    localparam int ROW_W       = (PAGE_ROWS > 1) ? $clog2(PAGE_ROWS) : 1;
    localparam int ADDR_CALC_W = 16;
    localparam int SENT_W      = 9;
    localparam int MEM_W       = 9;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result staging buffer
    localparam int RES_DEPTH = 3;
    localparam int RES_IDX_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // controller command codes
    localparam logic [7:0] CMD_EXTENDED  = 8'h21;
    localparam logic [7:0] CMD_BASIC     = 8'h20;
    localparam logic [7:0] CMD_SET_VOP   = 8'h80;
    localparam logic [7:0] CMD_SET_Y     = 8'h40;
    localparam logic [7:0] CMD_SET_X     = 8'h80;
    localparam logic [6:0] CONTRAST_MASK = 7'h7f;

    typedef enum logic [2:0] {
        OP_DRAW     = 3'd0,
        OP_READ     = 3'd1,
        OP_CLEAR    = 3'd2,
        OP_FLUSH    = 3'd3,
        OP_CONTRAST = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_CMD   = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_PIXEL = 2'd2,
        KIND_SKIP  = 2'd3
    } kind_t;

    // decoded command handed from front to back
    typedef struct packed {
        op_t               op;
        logic              in_range;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_idx;
        logic              color;
        logic [6:0]        level;
    } cmd_t;

    // one result beat
    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data;
        logic              pix;
        logic              done;
        logic [SENT_W-1:0] sent;
    } res_t;

    // queue status toward the front
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // back status toward the front
    typedef struct packed {
        logic clearing;
    } back_stat_t;

    function automatic res_t mk_res(kind_t kind, logic [7:0] data, logic pix,
                                    logic done, logic [SENT_W-1:0] sent);
        res_t r;
        r.kind = kind;
        r.data = data;
        r.pix  = pix;
        r.done = done;
        r.sent = sent;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/fdf_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module fdf_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [2:0]          s_operation,
    input  wire logic signed [7:0]   s_pos_x,
    input  wire logic signed [7:0]   s_pos_y,
    input  wire logic                s_pixel_color,
    input  wire logic [7:0]          s_contrast_level,
    input  wire fdf_pkg::q_stat_t    q_stat,
    input  wire fdf_pkg::back_stat_t back_stat,
    output logic                     q_push,
    output fdf_pkg::cmd_t            q_push_data
);

    logic                              f_valid_reg, f_valid_next;
    fdf_pkg::cmd_t                     f_cmd_reg, f_cmd_next;
    fdf_pkg::cmd_t                     dec_cmd;
    logic                              dec_keep;
    logic                              x_ok, y_ok, in_range;
    logic [fdf_pkg::ADDR_CALC_W-1:0]   blk_full;
    logic                              s_fire;

    // bounds check on the signed coordinates
    assign x_ok     = !s_pos_x[7] && (s_pos_x[6:0] < 7'(fdf_pkg::SCREEN_WIDTH));
    assign y_ok     = !s_pos_y[7] && (s_pos_y[6:0] < 7'(fdf_pkg::SCREEN_HEIGHT));
    assign in_range = x_ok && y_ok;

    // byte index: column plus page times width
    assign blk_full = fdf_pkg::ADDR_CALC_W'(s_pos_y[6:3])
                    * fdf_pkg::ADDR_CALC_W'(fdf_pkg::SCREEN_WIDTH)
                    + fdf_pkg::ADDR_CALC_W'(s_pos_x[6:0]);

    // classify the incoming beat
    always_comb begin
        dec_cmd.op       = fdf_pkg::op_t'(s_operation);
        dec_cmd.in_range = in_range;
        dec_cmd.addr     = in_range ? blk_full[fdf_pkg::ADDR_W-1:0] : '0;
        dec_cmd.bit_idx  = s_pos_y[2:0];
        dec_cmd.color    = s_pixel_color;
        dec_cmd.level    = s_contrast_level[6:0] & fdf_pkg::CONTRAST_MASK;
        unique case (fdf_pkg::op_t'(s_operation))
            fdf_pkg::OP_DRAW:     dec_keep = in_range;
            fdf_pkg::OP_READ,
            fdf_pkg::OP_CLEAR,
            fdf_pkg::OP_FLUSH,
            fdf_pkg::OP_CONTRAST: dec_keep = 1'b1;
            default:              dec_keep = 1'b0;
        endcase
    end

    // one holding stage in front of the queue
    assign s_ready     = (!f_valid_reg || !q_stat.full) && !back_stat.clearing;
    assign s_fire      = s_valid && s_ready;
    assign q_push      = f_valid_reg && !q_stat.full;
    assign q_push_data = f_cmd_reg;

    always_comb begin
        f_valid_next = f_valid_reg;
        f_cmd_next   = f_cmd_reg;
        if (s_fire) begin
            f_valid_next = dec_keep;
            f_cmd_next   = dec_cmd;
        end else if (q_push) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        f_cmd_reg <= f_cmd_next;
    end

endmodule

`default_nettype wire

/* rtl/fdf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fdf_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire fdf_pkg::cmd_t    push_data,
    input  wire logic             pop,
    output fdf_pkg::cmd_t         pop_data,
    output fdf_pkg::q_stat_t      stat
);

    fdf_pkg::cmd_t                entry_reg [fdf_pkg::QUEUE_DEPTH];
    logic [fdf_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [fdf_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [fdf_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == fdf_pkg::QCNT_W'(fdf_pkg::QUEUE_DEPTH));
    assign pop_data   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == fdf_pkg::QPTR_W'(fdf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == fdf_pkg::QPTR_W'(fdf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // queue integrity
    `FDF_NEVER(a_push_full, push && stat.full && !pop)
    `FDF_NEVER(a_pop_empty, pop && stat.empty)
    `FDF_NEVER(a_count_range, count_reg > fdf_pkg::QCNT_W'(fdf_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

/* rtl/fdf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fdf_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire fdf_pkg::q_stat_t       q_stat,
    input  wire fdf_pkg::cmd_t          q_data,
    output logic                        q_pop,
    output fdf_pkg::back_stat_t         back_stat,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_kind,
    output logic [7:0]                  m_out_byte,
    output logic                        m_pixel_value,
    output logic                        m_flush_done,
    output logic [8:0]                  m_blocks_sent,
    output logic                        m_last
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EMIT
    } state_t;

    state_t                           state_reg, state_next;
    fdf_pkg::cmd_t                    cmd_reg, cmd_next;
    logic [fdf_pkg::ADDR_W-1:0]       sweep_reg, sweep_next;
    logic [fdf_pkg::ADDR_W-1:0]       cursor_reg, cursor_next;
    logic [fdf_pkg::COL_W-1:0]        col_reg, col_next;
    logic [fdf_pkg::ROW_W-1:0]        row_reg, row_next;
    logic [fdf_pkg::SENT_W-1:0]       sent_reg, sent_next;
    logic                             skip_reg, skip_next;
    fdf_pkg::res_t                    res_buf_reg [fdf_pkg::RES_DEPTH];
    fdf_pkg::res_t                    res_buf_next [fdf_pkg::RES_DEPTH];
    logic [fdf_pkg::RES_CNT_W-1:0]    res_cnt_reg, res_cnt_next;
    logic [fdf_pkg::RES_IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic                             m_valid_reg, m_valid_next;
    fdf_pkg::res_t                    m_res_reg, m_res_next;
    logic                             m_last_reg, m_last_next;

    // frame store: bit 8 dirty mark, bits 7:0 pixel column
    logic [fdf_pkg::MEM_W-1:0]        mem [fdf_pkg::STORE_SIZE];
    logic                             mem_we;
    logic [fdf_pkg::ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic [fdf_pkg::MEM_W-1:0]        mem_wdata, mem_rdata_reg;

    logic                             out_free;
    logic                             final_blk;
    logic [7:0]                       bit_mask;
    logic [7:0]                       rd_byte;
    logic                             rd_dirty;
    logic [fdf_pkg::SENT_W-1:0]       sent_inc;
    logic [fdf_pkg::RES_IDX_W-1:0]    fill_idx;
    logic                             emit_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign final_blk = (cursor_reg == fdf_pkg::ADDR_W'(fdf_pkg::STORE_SIZE - 1));
    assign bit_mask  = 8'(1) << cmd_reg.bit_idx;
    assign rd_byte   = mem_rdata_reg[7:0];
    assign rd_dirty  = mem_rdata_reg[8];
    assign sent_inc  = sent_reg + 1'b1;
    assign emit_last = (fdf_pkg::RES_CNT_W'(res_idx_reg) == res_cnt_reg - 1'b1);

    assign back_stat.clearing = (state_reg == S_CLEAR);

    // sequencer next-state and result staging
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        sweep_next   = sweep_reg;
        cursor_next  = cursor_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        sent_next    = sent_reg;
        skip_next    = skip_reg;
        res_buf_next = res_buf_reg;
        res_cnt_next = res_cnt_reg;
        res_idx_next = res_idx_reg;
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        m_last_next  = m_last_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = cmd_reg.addr;
        mem_wdata    = mem_rdata_reg;
        mem_raddr    = (q_data.op == fdf_pkg::OP_FLUSH) ? cursor_reg : q_data.addr;
        fill_idx     = '0;

        // result register drains on the handshake
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                // one store entry per cycle: zero pixels, dirty mark set
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = {1'b1, 8'h00};
                if (sweep_reg == fdf_pkg::ADDR_W'(fdf_pkg::STORE_SIZE - 1)) begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            S_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    case (q_data.op)
                        fdf_pkg::OP_CLEAR: begin
                            state_next = S_CLEAR;
                        end
                        fdf_pkg::OP_CONTRAST: begin
                            res_buf_next[0] = fdf_pkg::mk_res(fdf_pkg::KIND_CMD,
                                fdf_pkg::CMD_EXTENDED, 1'b0, 1'b0, '0);
                            res_buf_next[1] = fdf_pkg::mk_res(fdf_pkg::KIND_CMD,
                                fdf_pkg::CMD_SET_VOP | {1'b0, q_data.level}, 1'b0, 1'b0, '0);
                            res_buf_next[2] = fdf_pkg::mk_res(fdf_pkg::KIND_CMD,
                                fdf_pkg::CMD_BASIC, 1'b0, 1'b0, '0);
                            res_cnt_next    = fdf_pkg::RES_CNT_W'(3);
                            res_idx_next    = '0;
                            state_next      = S_EMIT;
                        end
                        default: begin
                            state_next = S_LOOK;
                        end
                    endcase
                end
            end

            S_LOOK: begin
                res_idx_next = '0;
                case (cmd_reg.op)
                    fdf_pkg::OP_DRAW: begin
                        // read-modify-write of the addressed byte
                        mem_we     = 1'b1;
                        mem_waddr  = cmd_reg.addr;
                        mem_wdata  = {1'b1, cmd_reg.color ? (rd_byte & ~bit_mask)
                                                          : (rd_byte | bit_mask)};
                        state_next = S_IDLE;
                    end
                    fdf_pkg::OP_READ: begin
                        res_buf_next[0] = fdf_pkg::mk_res(fdf_pkg::KIND_PIXEL, 8'h00,
                            cmd_reg.in_range && rd_byte[cmd_reg.bit_idx], 1'b0, '0);
                        res_cnt_next    = fdf_pkg::RES_CNT_W'(1);
                        state_next      = S_EMIT;
                    end
                    default: begin
                        // flush step for the byte under the cursor
                        if (col_reg == '0) begin
                            res_buf_next[fill_idx] = fdf_pkg::mk_res(fdf_pkg::KIND_CMD,
                                fdf_pkg::CMD_SET_Y | 8'(row_reg), 1'b0, 1'b0, '0);
                            fill_idx = fill_idx + 1'b1;
                        end
                        if (rd_dirty) begin
                            if (skip_reg) begin
                                res_buf_next[fill_idx] = fdf_pkg::mk_res(fdf_pkg::KIND_CMD,
                                    fdf_pkg::CMD_SET_X | 8'(col_reg), 1'b0, 1'b0, '0);
                                fill_idx = fill_idx + 1'b1;
                            end
                            skip_next = 1'b0;
                            sent_next = sent_inc;
                            mem_we    = 1'b1;
                            mem_waddr = cursor_reg;
                            mem_wdata = {1'b0, rd_byte};
                            res_buf_next[fill_idx] = fdf_pkg::mk_res(fdf_pkg::KIND_DATA,
                                rd_byte, 1'b0, final_blk, final_blk ? sent_inc : '0);
                        end else begin
                            skip_next = 1'b1;
                            res_buf_next[fill_idx] = fdf_pkg::mk_res(fdf_pkg::KIND_SKIP,
                                8'h00, 1'b0, final_blk, final_blk ? sent_reg : '0);
                        end
                        res_cnt_next = fdf_pkg::RES_CNT_W'(fill_idx) + 1'b1;

                        // cursor advance with column and page tracking
                        if (final_blk) begin
                            cursor_next = '0;
                            col_next    = '0;
                            row_next    = '0;
                            skip_next   = 1'b1;
                            sent_next   = '0;
                        end else begin
                            cursor_next = cursor_reg + 1'b1;
                            if (col_reg == fdf_pkg::COL_W'(fdf_pkg::SCREEN_WIDTH - 1)) begin
                                col_next = '0;
                                row_next = row_reg + 1'b1;
                            end else begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_EMIT: begin
                // one staged result per beat into the output register
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_buf_reg[res_idx_reg];
                    m_last_next  = emit_last;
                    if (emit_last) begin
                        state_next = S_IDLE;
                    end else begin
                        res_idx_next = res_idx_reg + 1'b1;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            sweep_reg   <= '0;
            cursor_reg  <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            sent_reg    <= '0;
            skip_reg    <= 1'b1;
            res_cnt_reg <= '0;
            res_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            cursor_reg  <= cursor_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            sent_reg    <= sent_next;
            skip_reg    <= skip_next;
            res_cnt_reg <= res_cnt_next;
            res_idx_reg <= res_idx_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg     <= cmd_next;
        res_buf_reg <= res_buf_next;
        m_res_reg   <= m_res_next;
        m_last_reg  <= m_last_next;
    end

    // frame store memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_res_reg.kind;
    assign m_out_byte    = m_res_reg.data;
    assign m_pixel_value = m_res_reg.pix;
    assign m_flush_done  = m_res_reg.done;
    assign m_blocks_sent = m_res_reg.sent;
    assign m_last        = m_last_reg;

    // sequencer checks
    `FDF_NEVER(a_no_write_idle, (state_reg == S_IDLE) && mem_we)
    `FDF_NEVER(a_emit_has_work, (state_reg == S_EMIT) && (res_cnt_reg == '0))
    `FDF_NEVER(a_cursor_range, cursor_reg > fdf_pkg::ADDR_W'(fdf_pkg::STORE_SIZE - 1))
    `FDF_NEVER(a_done_is_last, m_valid_reg && m_res_reg.done && !m_last_reg)
    `FDF_ASSERT(a_pop_only_idle, q_pop |-> (state_reg == S_IDLE))

endmodule

`default_nettype wire

/* rtl/framebuffer_dirty_flush_core.sv */
// path: an item passes the front holding register and the queue to the back end;
//   results are staged in idle (contrast) or look (read, flush), then the output register
//   sends one result beat per cycle while m_ready is high
// sequencing: a new command is popped only in idle; clear writes one store byte per cycle
// reset: synchronous, active low; then a sweep of all 504 bytes zeroes the frame store
//   and sets every dirty mark, and s_ready stays low until it completes
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_dirty_flush_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [2:0]        s_operation,
    input  wire logic signed [7:0] s_pos_x,
    input  wire logic signed [7:0] s_pos_y,
    input  wire logic              s_pixel_color,
    input  wire logic [7:0]        s_contrast_level,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_kind,
    output logic [7:0]             m_out_byte,
    output logic                   m_pixel_value,
    output logic                   m_flush_done,
    output logic [8:0]             m_blocks_sent,
    output logic                   m_last
);

    fdf_pkg::q_stat_t    q_stat;
    fdf_pkg::back_stat_t back_stat;
    fdf_pkg::cmd_t       push_data;
    fdf_pkg::cmd_t       pop_data;
    logic                push;
    logic                pop;

    // decode and bounds check
    fdf_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pixel_color    (s_pixel_color),
        .s_contrast_level (s_contrast_level),
        .q_stat           (q_stat),
        .back_stat        (back_stat),
        .q_push           (push),
        .q_push_data      (push_data)
    );

    // command queue
    fdf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // frame store, flush sequencer and result register
    fdf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .q_data        (pop_data),
        .q_pop         (pop),
        .back_stat     (back_stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_byte    (m_out_byte),
        .m_pixel_value (m_pixel_value),
        .m_flush_done  (m_flush_done),
        .m_blocks_sent (m_blocks_sent),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire
